FILE: rtl/core/pli_pkg.sv
// Shared types and constants for the plane / line intersection unit.
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

   // Restoring divider steps: quotient bits produced before rounding.
   localparam int unsigned DivSteps = 34;

   // |den| below this value (1E-6 in Q.60, rounded up) means parallel.
   localparam logic [63:0] DenTol = 64'd1152921504607;

   // Rounded quotient above 2^33 always saturates.
   localparam logic [34:0] QuoLimit = 35'h2_0000_0000;

   localparam logic [31:0] NormalZReset = 32'h4000_0000;

   typedef enum logic [2:0] {
      CSR_NORMAL_X = 3'd0,
      CSR_NORMAL_Y = 3'd1,
      CSR_NORMAL_Z = 3'd2,
      CSR_ANCHOR_X = 3'd3,
      CSR_ANCHOR_Y = 3'd4,
      CSR_ANCHOR_Z = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic               func;
      logic signed [31:0] line_point_x;
      logic signed [31:0] line_point_y;
      logic signed [31:0] line_point_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
      logic [30:0]        seg_length;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] cross_x;
      logic signed [31:0] cross_y;
      logic signed [31:0] cross_z;
   } rsp_type;

   // Plane registers, element 0 is x.
   typedef struct packed {
      logic [2:0][31:0] normal;
      logic [2:0][31:0] anchor;
   } cfg_type;

   // One coordinate lane inside the divider.
   typedef struct packed {
      logic [63:0] rem;    // partial remainder
      logic [33:0] word;   // dividend bits shift out on top, quotient bits in below
      logic [31:0] point;  // line start coordinate
      logic        neg;    // offset sign
      logic        ovf;    // quotient certainly saturates
   } lane_type;

   typedef struct packed {
      logic             valid;
      logic             hit;
      logic [63:0]      dd;
      lane_type [2:0]   lane;
   } div_type;

endpackage

`default_nettype wire

FILE: rtl/core/plane_line_intersect_unit.sv
// Top level of the plane / line intersection unit.
//
//   channel   direction  ports                            moves
//   request   in         req_valid, req_stall, req_data   one line query
//   response  out        rsp_valid, rsp_stall, rsp_data   hit flag and point
//   csr       in         csr_we, csr_index, csr_wdata     plane normal and anchor
//
// One request enters per cycle while req_stall is low; each response leaves
// after 7 front stages, 34 divider steps, 3 rounding and saturation stages.
// The 34 one-bit divider steps set the latency; throughput is one per cycle unstalled.
// Reset clears all valid bits and sets the normal to +z and the anchor to zero.
// A stalled response is parked in a skid register; the pipe keeps moving that
// cycle and freezes (request stall high) only while the skid register is full.
`timescale 1ns / 1ps
`default_nettype none

module plane_line_intersect_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire pli_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output pli_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [2:0]       csr_index,
   input  wire logic [31:0]      csr_wdata
);
   import pli_pkg::*;

   cfg_type   cfg_ff;
   logic      en;
   div_type   stage [DivSteps + 1];
   logic      last_valid;
   rsp_type   last_data;
   logic      skid_valid_ff;
   rsp_type   skid_data_ff;

   // Plane registers; writes to unused indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.normal <= {NormalZReset, 32'd0, 32'd0};
         cfg_ff.anchor <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_NORMAL_X: cfg_ff.normal[0] <= csr_wdata;
            CSR_NORMAL_Y: cfg_ff.normal[1] <= csr_wdata;
            CSR_NORMAL_Z: cfg_ff.normal[2] <= csr_wdata;
            CSR_ANCHOR_X: cfg_ff.anchor[0] <= csr_wdata;
            CSR_ANCHOR_Y: cfg_ff.anchor[1] <= csr_wdata;
            CSR_ANCHOR_Z: cfg_ff.anchor[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance the whole pipe unless the skid register holds a response.
   assign en        = !skid_valid_ff;
   assign req_stall = !en;

   // Dot products, t numerator and denominator, segment bounds.
   pli_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .in_data  (req_data),
      .cfg      (cfg_ff),
      .out_data (stage[0])
   );

   // One quotient bit per stage for each coordinate offset.
   for (genvar k = 0; k < DivSteps; k++) begin : g_div
      pli_div_step u_step (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_data  (stage[k]),
         .out_data (stage[k + 1])
      );
   end

   // Round, offset from the start point, saturate, zero on a miss.
   pli_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_data   (stage[DivSteps]),
      .out_valid (last_valid),
      .out_data  (last_data)
   );

   // Park the last stage's response when the consumer stalls; drain it first.
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (!rsp_stall) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (last_valid && rsp_stall) begin
         skid_valid_ff <= 1'b1;
         skid_data_ff  <= last_data;
      end
   end

   assign rsp_valid = skid_valid_ff || last_valid;
   assign rsp_data  = skid_valid_ff ? skid_data_ff : last_data;

`ifndef SYNTHESIS
   // The skid register fills only because the consumer stalled.
   assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_stall))
      else $error("skid register filled without a response stall");

   // Requests are held off only while a response is waiting.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response pending");

   // A miss carries zero coordinates.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |->
         (rsp_data.cross_x == '0 && rsp_data.cross_y == '0 && rsp_data.cross_z == '0))
      else $error("miss response with nonzero coordinates");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/pli_front.sv
// Front stages: dot products, magnitudes, product partials and segment test.
`timescale 1ns / 1ps
`default_nettype none

module pli_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire pli_pkg::req_type in_data,
   input  wire pli_pkg::cfg_type cfg,
   output pli_pkg::div_type      out_data
);
   import pli_pkg::*;

   // stage 0: point minus anchor
   logic                v0_ff, func0_ff;
   logic [30:0]         len0_ff;
   logic [2:0][31:0]    p0_ff, d0_ff;
   logic signed [32:0]  diff0_ff [3];
   // stage 1: products
   logic                v1_ff, func1_ff;
   logic [30:0]         len1_ff;
   logic [2:0][31:0]    p1_ff, d1_ff;
   logic signed [63:0]  pd1_ff [3], pd1_in [3];
   logic signed [64:0]  pn1_ff [3], pn1_in [3];
   // stage 2: sums
   logic                v2_ff, func2_ff;
   logic [30:0]         len2_ff;
   logic [2:0][31:0]    p2_ff, d2_ff;
   logic signed [65:0]  den2_ff;
   logic signed [66:0]  num2_ff;
   // stage 3: magnitudes
   logic                v3_ff, func3_ff, par3_ff, tneg3_ff;
   logic [30:0]         len3_ff;
   logic [2:0][31:0]    p3_ff, dm3_ff;
   logic [2:0]          dneg3_ff;
   logic [63:0]         dd3_ff;
   logic [64:0]         tn3_ff;
   logic [65:0]         den_abs;
   logic [66:0]         num_abs;
   // stage 4: partial products
   logic                v4_ff, func4_ff, par4_ff, tneg4_ff;
   logic [2:0][31:0]    p4_ff;
   logic [2:0]          neg4_ff;
   logic [63:0]         dd4_ff;
   logic [64:0]         tn4_ff;
   logic [62:0]         plo4_ff, phi4_ff;
   logic [63:0]         qlo4_ff [3];
   logic [64:0]         qhi4_ff [3];
   // stage 5: combined products
   logic                v5_ff, func5_ff, par5_ff, tneg5_ff;
   logic [2:0][31:0]    p5_ff;
   logic [2:0]          neg5_ff;
   logic [63:0]         dd5_ff;
   logic [64:0]         tn5_ff;
   logic [94:0]         lenxdd5_ff;
   logic [96:0]         prod5_ff [3];
   // stage 6: tests, divider entry
   div_type             out_ff, out_in;
   logic                reject;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pd1_in[i] = $signed(cfg.normal[i]) * $signed(d0_ff[i]);
         pn1_in[i] = $signed(cfg.normal[i]) * diff0_ff[i];
      end
   end

   always_comb begin
      den_abs = den2_ff[65] ? 66'(-den2_ff) : den2_ff;
      num_abs = num2_ff[66] ? 67'(-num2_ff) : num2_ff;
   end

   always_comb begin
      reject = func5_ff && (tneg5_ff || ({tn5_ff, 30'b0} > lenxdd5_ff));
      out_in.valid = v5_ff;
      out_in.hit   = !par5_ff && !reject;
      out_in.dd    = dd5_ff;
      for (int i = 0; i < 3; i++) begin
         out_in.lane[i].rem   = {1'b0, prod5_ff[i][96:34]};
         out_in.lane[i].word  = prod5_ff[i][33:0];
         out_in.lane[i].point = p5_ff[i];
         out_in.lane[i].neg   = neg5_ff[i];
         out_in.lane[i].ovf   = {1'b0, prod5_ff[i]} >= {dd5_ff, 34'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         func0_ff <= in_data.func;
         len0_ff  <= in_data.seg_length;
         p0_ff    <= {in_data.line_point_z, in_data.line_point_y, in_data.line_point_x};
         d0_ff    <= {in_data.dir_z, in_data.dir_y, in_data.dir_x};
         diff0_ff[0] <= 33'(in_data.line_point_x) - 33'($signed(cfg.anchor[0]));
         diff0_ff[1] <= 33'(in_data.line_point_y) - 33'($signed(cfg.anchor[1]));
         diff0_ff[2] <= 33'(in_data.line_point_z) - 33'($signed(cfg.anchor[2]));

         func1_ff <= func0_ff;
         len1_ff  <= len0_ff;
         p1_ff    <= p0_ff;
         d1_ff    <= d0_ff;
         pd1_ff   <= pd1_in;
         pn1_ff   <= pn1_in;

         func2_ff <= func1_ff;
         len2_ff  <= len1_ff;
         p2_ff    <= p1_ff;
         d2_ff    <= d1_ff;
         den2_ff  <= 66'(pd1_ff[0]) + 66'(pd1_ff[1]) + 66'(pd1_ff[2]);
         num2_ff  <= 67'(pn1_ff[0]) + 67'(pn1_ff[1]) + 67'(pn1_ff[2]);

         func3_ff <= func2_ff;
         len3_ff  <= len2_ff;
         p3_ff    <= p2_ff;
         dd3_ff   <= den_abs[63:0];
         par3_ff  <= den_abs[63:0] < DenTol;
         tn3_ff   <= num_abs[64:0];
         tneg3_ff <= (num2_ff != '0) && (num2_ff[66] == den2_ff[65]);
         for (int i = 0; i < 3; i++) begin
            dneg3_ff[i] <= d2_ff[i][31];
            dm3_ff[i]   <= d2_ff[i][31] ? (~d2_ff[i] + 32'd1) : d2_ff[i];
         end

         func4_ff <= func3_ff;
         par4_ff  <= par3_ff;
         tneg4_ff <= tneg3_ff;
         p4_ff    <= p3_ff;
         dd4_ff   <= dd3_ff;
         tn4_ff   <= tn3_ff;
         plo4_ff  <= 63'(len3_ff) * 63'(dd3_ff[31:0]);
         phi4_ff  <= 63'(len3_ff) * 63'(dd3_ff[63:32]);
         for (int i = 0; i < 3; i++) begin
            neg4_ff[i] <= dneg3_ff[i] ^ tneg3_ff;
            qlo4_ff[i] <= 64'(dm3_ff[i]) * 64'(tn3_ff[31:0]);
            qhi4_ff[i] <= 65'(dm3_ff[i]) * 65'(tn3_ff[64:32]);
         end

         func5_ff   <= func4_ff;
         par5_ff    <= par4_ff;
         tneg5_ff   <= tneg4_ff;
         p5_ff      <= p4_ff;
         neg5_ff    <= neg4_ff;
         dd5_ff     <= dd4_ff;
         tn5_ff     <= tn4_ff;
         lenxdd5_ff <= {32'b0, plo4_ff} + {phi4_ff, 32'b0};
         for (int i = 0; i < 3; i++) begin
            prod5_ff[i] <= {33'b0, qlo4_ff[i]} + {qhi4_ff[i], 32'b0};
         end
      end
   end

   assign out_data = out_ff;

endmodule

`default_nettype wire

FILE: rtl/core/pli_div_step.sv
// One registered restoring-division step for the three coordinate lanes.
`timescale 1ns / 1ps
`default_nettype none

module pli_div_step (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire pli_pkg::div_type in_data,
   output pli_pkg::div_type      out_data
);
   import pli_pkg::*;

   div_type     out_ff, out_in;
   logic [64:0] shifted [3];
   logic [64:0] trial [3];
   logic        take [3];

   always_comb begin
      out_in = in_data;
      for (int i = 0; i < 3; i++) begin
         shifted[i] = {in_data.lane[i].rem, in_data.lane[i].word[33]};
         trial[i]   = shifted[i] - {1'b0, in_data.dd};
         take[i]    = shifted[i] >= {1'b0, in_data.dd};
         out_in.lane[i].rem  = take[i] ? trial[i][63:0] : shifted[i][63:0];
         out_in.lane[i].word = {in_data.lane[i].word[32:0], take[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff <= out_in;
      end
   end

   assign out_data = out_ff;

endmodule

`default_nettype wire

FILE: rtl/core/pli_back.sv
// Back stages: round the quotient, offset the start point by it, saturate, zero a miss.
`timescale 1ns / 1ps
`default_nettype none

module pli_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire pli_pkg::div_type in_data,
   output logic                  out_valid,
   output pli_pkg::rsp_type      out_data
);
   import pli_pkg::*;

   // round
   logic              v1_ff, hit1_ff;
   logic [34:0]       q1_ff [3];
   logic [2:0]        big1_ff, neg1_ff;
   logic [2:0][31:0]  p1_ff;
   // add
   logic              v2_ff, hit2_ff;
   logic [2:0]        big2_ff, neg2_ff;
   logic signed [35:0] sum2_ff [3];
   // saturate
   logic              v3_ff;
   rsp_type           rsp_ff;
   logic [31:0]       coord [3];
   logic [34:0]       q_round [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q_round[i] = {1'b0, in_data.lane[i].word} +
                      {34'b0, in_data.lane[i].rem >= (in_data.dd - in_data.lane[i].rem)};
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (big2_ff[i]) begin
            coord[i] = neg2_ff[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else if (sum2_ff[i][35:31] != {5{sum2_ff[i][35]}}) begin
            coord[i] = sum2_ff[i][35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else begin
            coord[i] = sum2_ff[i][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_data.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit1_ff <= in_data.hit;
         for (int i = 0; i < 3; i++) begin
            q1_ff[i]   <= q_round[i];
            big1_ff[i] <= in_data.lane[i].ovf || (q_round[i] > QuoLimit);
            neg1_ff[i] <= in_data.lane[i].neg;
            p1_ff[i]   <= in_data.lane[i].point;
         end

         hit2_ff <= hit1_ff;
         big2_ff <= big1_ff;
         neg2_ff <= neg1_ff;
         for (int i = 0; i < 3; i++) begin
            sum2_ff[i] <= neg1_ff[i]
               ? $signed({{4{p1_ff[i][31]}}, p1_ff[i]}) - $signed({1'b0, q1_ff[i]})
               : $signed({{4{p1_ff[i][31]}}, p1_ff[i]}) + $signed({1'b0, q1_ff[i]});
         end

         rsp_ff.hit     <= hit2_ff;
         rsp_ff.cross_x <= hit2_ff ? coord[0] : '0;
         rsp_ff.cross_y <= hit2_ff ? coord[1] : '0;
         rsp_ff.cross_z <= hit2_ff ? coord[2] : '0;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the plane / line intersection unit.
`timescale 1ns / 1ps

module tb;
   import pli_pkg::*;

   localparam int unsigned Latency = 44;
   localparam int unsigned StallLimit = 20000;
   localparam logic [63:0] DenTolerance = 64'd1152921504607;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_we;
   logic [2:0] csr_index;
   logic [31:0] csr_wdata;

   plane_line_intersect_unit u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Plane state as the predictor sees it: normal Q2.30, anchor Q16.16.
   logic signed [31:0] plane_normal [3];
   logic signed [31:0] plane_anchor [3];

   req_type pending_reqs [$];
   rsp_type expected_hits [$];

   int unsigned fail_count;
   int unsigned idle_cycles;
   bit sender_calm;    // no random gaps on the request side
   bit receiver_calm;  // no random stalls on the response side
   bit hold_go;        // start the forced receiver hold-off
   bit hold_off;       // receiver held off, counted in its own process

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Work out the exact intersection, rounded and saturated per coordinate.
   function automatic rsp_type predict_crossing(req_type rq);
      rsp_type res;
      logic signed [31:0] pnt [3];
      logic signed [31:0] dir [3];
      logic signed [127:0] den;
      logic signed [127:0] num;
      logic signed [127:0] tnum;
      logic [127:0] dmag;
      logic [127:0] tmag;
      logic [127:0] prod;
      logic [127:0] quo;
      logic [127:0] rem;
      logic signed [127:0] coord;
      bit negative;
      begin
         res = '0;
         pnt[0] = rq.line_point_x;
         pnt[1] = rq.line_point_y;
         pnt[2] = rq.line_point_z;
         dir[0] = rq.dir_x;
         dir[1] = rq.dir_y;
         dir[2] = rq.dir_z;
         den = 0;
         num = 0;
         for (int i = 0; i < 3; i++) begin
            den += 128'(signed'(plane_normal[i])) * 128'(signed'(dir[i]));
            num += 128'(signed'(plane_normal[i]))
                   * (128'(signed'(pnt[i])) - 128'(signed'(plane_anchor[i])));
         end
         dmag = (den < 0) ? 128'(-den) : 128'(den);
         // Too close to parallel: report a miss.
         if (dmag < 128'(DenTolerance)) return res;
         // Sign of t folds in the sign of den; magnitude of den divides later.
         tnum = (den < 0) ? num : -num;
         tmag = (tnum < 0) ? 128'(-tnum) : 128'(tnum);
         if (rq.func) begin
            // t < 0 or t > length rejects the segment; ends count as hits.
            if (tnum < 0) return res;
            if ((tmag << 30) > 128'(rq.seg_length) * dmag) return res;
         end
         res.hit = 1'b1;
         for (int i = 0; i < 3; i++) begin
            negative = (dir[i] < 0) != (tnum < 0);
            prod = ((dir[i] < 0) ? 128'(-128'(signed'(dir[i]))) : 128'(dir[i])) * tmag;
            quo = prod / dmag;
            rem = prod % dmag;
            if (rem >= dmag - rem) quo += 1;  // ties away from zero
            coord = negative ? 128'(signed'(pnt[i])) - signed'(quo)
                             : 128'(signed'(pnt[i])) + signed'(quo);
            if (quo > 128'h2_0000_0000 || coord > 128'sd2147483647)
               coord = negative ? -128'sd2147483648 : 128'sd2147483647;
            if (coord < -128'sd2147483648) coord = -128'sd2147483648;
            case (i)
               0: res.cross_x = coord[31:0];
               1: res.cross_y = coord[31:0];
               default: res.cross_z = coord[31:0];
            endcase
         end
         return res;
      end
   endfunction

   // Request driver: hold the payload while stalled, advance on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_hits.push_back(predict_crossing(req_data));
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && (sender_calm || $urandom_range(99) >= 11)) begin
               req_valid <= 1'b1;
               req_data <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Forced receiver hold-off, counted here in cycles.
   initial begin
      hold_off = 1'b0;
      wait (hold_go);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (200) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Response monitor and receiver stall generator.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_hits.size() == 0) begin
               $display("%0t: response with none expected: %p", $time, rsp_data);
               fail_count++;
            end else if (rsp_data !== expected_hits[0]) begin
               $display("%0t: mismatch expected %p actual %p", $time, expected_hits[0],
                        rsp_data);
               fail_count++;
               void'(expected_hits.pop_front());
            end else begin
               void'(expected_hits.pop_front());
            end
         end
         if (hold_off) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !receiver_calm && ($urandom_range(99) < 11);
         end
         // Count cycles with no acceptance on either channel.
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic logic [31:0] any_word();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   // A random line; most use unit-ish direction and modest points.
   function automatic req_type random_line(bit wild);
      req_type rq;
      begin
         rq.func = 1'($urandom_range(1));
         if (wild) begin
            rq.line_point_x = any_word();
            rq.line_point_y = any_word();
            rq.line_point_z = any_word();
            rq.dir_x = any_word();
            rq.dir_y = any_word();
            rq.dir_z = any_word();
            rq.seg_length = 31'($urandom);
         end else begin
            rq.line_point_x = $signed($urandom_range(2000000)) - 1000000;
            rq.line_point_y = $signed($urandom_range(2000000)) - 1000000;
            rq.line_point_z = $signed($urandom_range(2000000)) - 1000000;
            rq.dir_x = $signed($urandom_range(32'h6000_0000)) - 32'sh3000_0000;
            rq.dir_y = $signed($urandom_range(32'h6000_0000)) - 32'sh3000_0000;
            rq.dir_z = $signed($urandom_range(32'h6000_0000)) - 32'sh3000_0000;
            rq.seg_length = 31'($urandom_range(32'h0100_0000));
         end
         return rq;
      end
   endfunction

   // Write one plane register at an idle block.
   task automatic write_plane(csr_index_type idx, logic [31:0] value);
      begin
         @(posedge clock);
         csr_we <= 1'b1;
         csr_index <= idx;
         csr_wdata <= value;
         @(posedge clock);
         csr_we <= 1'b0;
         if (idx <= CSR_NORMAL_Z) plane_normal[idx] = value;
         else plane_anchor[idx - CSR_ANCHOR_X] = value;
      end
   endtask

   // Drain the pipe before touching the plane.
   task automatic wait_drained();
      begin
         while (pending_reqs.size() != 0 || req_valid || expected_hits.size() != 0)
            @(posedge clock);
         repeat (Latency + 4) @(posedge clock);
      end
   endtask

   task automatic load_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                             logic [31:0] ax, logic [31:0] ay, logic [31:0] az);
      begin
         wait_drained();
         write_plane(CSR_NORMAL_X, nx);
         write_plane(CSR_NORMAL_Y, ny);
         write_plane(CSR_NORMAL_Z, nz);
         write_plane(CSR_ANCHOR_X, ax);
         write_plane(CSR_ANCHOR_Y, ay);
         write_plane(CSR_ANCHOR_Z, az);
      end
   endtask

   task automatic queue_line(bit fn, int px, int py, int pz, int dx, int dy, int dz,
                             logic [30:0] len);
      req_type rq;
      begin
         rq.func = fn;
         rq.line_point_x = px;
         rq.line_point_y = py;
         rq.line_point_z = pz;
         rq.dir_x = dx;
         rq.dir_y = dy;
         rq.dir_z = dz;
         rq.seg_length = len;
         pending_reqs.push_back(rq);
      end
   endtask

   initial begin
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_NORMAL_X;
      csr_wdata = '0;
      fail_count = 0;
      idle_cycles = 0;
      hold_go = 1'b0;
      sender_calm = 1'b0;
      receiver_calm = 1'b0;
      plane_normal[0] = '0;
      plane_normal[1] = '0;
      plane_normal[2] = NormalZReset;
      plane_anchor[0] = '0;
      plane_anchor[1] = '0;
      plane_anchor[2] = '0;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset plane z = 0, one line along x, two along z.
      queue_line(0, 32'h0001_0000, 32'h0002_0000, 32'h000a_0000, 32'h4000_0000, 0, 0, 0);
      queue_line(0, 32'h0001_0000, 32'h0002_0000, 32'h000a_0000, 0, 0, 32'hc000_0000, 0);
      queue_line(0, 32'h0001_0000, 0, 32'h000a_0000, 0, 0, 32'h4000_0000, 0);
      // Segment ends: t exactly zero, exactly the length, just past it, and below zero.
      queue_line(1, 5, 6, 0, 0, 0, 32'h4000_0000, 0);
      queue_line(1, 0, 0, 32'hfffb_0000, 0, 0, 32'h4000_0000, 31'h0005_0000);
      queue_line(1, 0, 0, 32'hfffb_0000, 0, 0, 32'h4000_0000, 31'h0004_ffff);
      queue_line(1, 0, 0, 32'h0005_0000, 0, 0, 32'h4000_0000, 31'h7fff_ffff);
      // Line in the plane: parallel, no hit.
      queue_line(0, 7, 8, 0, 32'h4000_0000, 0, 0, 0);
      // Tiny den just above and below tolerance; overflow to both bounds.
      queue_line(0, 0, 0, 32'h0000_0001, 32'h4000_0000, 32'h7fff_ffff, 32'h0000_0432, 0);
      queue_line(0, 0, 0, 32'h0000_0001, 32'h4000_0000, 32'h7fff_ffff, 32'h0000_0431, 0);
      queue_line(0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h8000_0000, 32'h0000_1000, 31'h7fff_ffff);
      queue_line(1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
      wait_drained();

      // Walk through several planes, extremes included, with random lines.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: load_plane(32'h4000_0000, 0, 0, 32'h0003_0000, 0, 0);
            1: load_plane(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                          32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
            2: load_plane(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
            3: load_plane(32'h24f3_4e8b, 32'h24f3_4e8b, 32'h24f3_4e8b,
                          32'h0010_0000, 32'hfff0_0000, 32'h0000_8000);
            default: load_plane($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         endcase
         sender_calm = (phase == 2);
         receiver_calm = (phase == 2);
         for (int k = 0; k < 220; k++) pending_reqs.push_back(random_line($urandom_range(4) == 0));
         if (phase == 1) begin
            // Long receiver hold-off while requests keep coming in.
            repeat (30) @(posedge clock);
            hold_go = 1'b1;
         end
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
